FILE: design/ept_pkg.sv
`default_nettype none

package ept_pkg;

  // Field widths
  localparam int CNT_W      = 16;
  localparam int POS_W      = 32;
  localparam int ANGLE_W    = 16;
  localparam int BASE_W     = 16;
  localparam int LIMIT_W    = 15;
  localparam int GAIN_W     = 10;
  localparam int SPEED_W    = 25;
  localparam int HALF_W     = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Default structure
  localparam int DEF_WINDOW_DEPTH = 4;
  localparam int DEF_DECIMATION   = 8;

  // Register reset values
  localparam logic [BASE_W-1:0]  RST_ANGLE_BASE      = '0;
  localparam logic [POS_W-1:0]   RST_ANGLE_BIAS      = '0;
  localparam logic [ANGLE_W-1:0] RST_ANGLE_PER_COUNT = ANGLE_W'(1);
  localparam logic [LIMIT_W-1:0] RST_SPEED_LIMIT     = LIMIT_W'(200);
  localparam logic [GAIN_W-1:0]  RST_SPEED_GAIN      = GAIN_W'(375);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ANGLE_BASE      = 3'd0,
    CFG_ANGLE_BIAS      = 3'd1,
    CFG_ANGLE_PER_COUNT = 3'd2,
    CFG_SPEED_LIMIT     = 3'd3,
    CFG_SPEED_GAIN      = 3'd4
  } cfg_idx_t;

endpackage

`default_nettype wire

FILE: design/encoder_position_speed_tracker.sv
`default_nettype none

// Encoder position and speed tracker. Each in_ beat carries one sample of a
// free-running 16-bit quadrature counter; each sample gives exactly one out_
// beat with direction, 32-bit extended position (revolutions in the top half),
// offset position, electrical angle and, on every DECIMATION-th sample, a
// speed value from a WINDOW_DEPTH-entry sliding sum of count differences,
// clamped to +-speed_limit, halved (rounding down) and scaled by speed_gain.
// Throughput is one sample per clock while out_tready is high. An in_ beat
// passes three register stages before its out_ beat is shown: stage 1 is
// loaded and the tracking state is updated from the count at acceptance,
// the angle product, offset and clamp follow in a second register stage,
// and the speed multiply fills the output register. Back-pressure on
// out_ ripples back stage by stage, so bubbles are squeezed out and in_tready
// only drops once all three stages are occupied. Configuration writes are
// always accepted (cfg_ready tied high); indexes beyond speed_gain are
// dropped. Write registers only while no beat is in flight.
module encoder_position_speed_tracker
  import ept_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter int DECIMATION   = DEF_DECIMATION
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // sample stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [15:0]           in_tdata,   // [15:0] counter_value
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [0] reverse, [32:1] position, [64:33] offset_position,
  // [80:65] electrical_angle, [105:81] speed, [111:106] zero
  output logic [111:0]               out_tdata,
  output logic                       out_tuser,  // [0] speed_valid
  // register writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SUM_W = CNT_W + $clog2(WINDOW_DEPTH);
  localparam int CMP_W = SUM_W + 1;
  localparam int REV_W = POS_W - CNT_W;
  localparam int PROD_W = HALF_W + GAIN_W + 1;

  // ---------------------------------------------------------------- config
  logic [BASE_W-1:0]  angle_base_r;
  logic [POS_W-1:0]   angle_bias_r;
  logic [ANGLE_W-1:0] angle_per_count_r;
  logic [LIMIT_W-1:0] speed_limit_r;
  logic [GAIN_W-1:0]  speed_gain_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_base_r      <= RST_ANGLE_BASE;
      angle_bias_r      <= RST_ANGLE_BIAS;
      angle_per_count_r <= RST_ANGLE_PER_COUNT;
      speed_limit_r     <= RST_SPEED_LIMIT;
      speed_gain_r      <= RST_SPEED_GAIN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ANGLE_BASE:      angle_base_r      <= cfg_data[BASE_W-1:0];
        CFG_ANGLE_BIAS:      angle_bias_r      <= cfg_data[POS_W-1:0];
        CFG_ANGLE_PER_COUNT: angle_per_count_r <= cfg_data[ANGLE_W-1:0];
        CFG_SPEED_LIMIT:     speed_limit_r     <= cfg_data[LIMIT_W-1:0];
        CFG_SPEED_GAIN:      speed_gain_r      <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------ pipeline control
  logic s1_v_r, s2_v_r, out_v_r;
  logic out_adv, s2_ready, s1_ready, in_fire;

  assign out_adv   = !out_v_r || out_tready;
  assign s2_ready  = !s2_v_r || out_adv;
  assign s1_ready  = !s1_v_r || s2_ready;
  assign in_tready = s1_ready;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_r <= in_fire;
      end
      if (s2_ready) begin
        s2_v_r <= s1_v_r;
      end
      if (out_adv) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  // ------------------------------------------- tracking state (acceptance)
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] prev_r;
  logic [REV_W-1:0] rev_r, rev_nxt;
  logic             dir_r, dir_nxt;
  logic [CNT_W-1:0] diff;

  assign cnt  = in_tdata[CNT_W-1:0];
  assign diff = cnt - prev_r;

  // half-range step counts as reverse; zero step holds everything
  always_comb begin
    rev_nxt = rev_r;
    dir_nxt = dir_r;
    if (diff[CNT_W-1]) begin
      if (cnt > prev_r) begin
        rev_nxt = rev_r - REV_W'(1);
      end
      dir_nxt = 1'b1;
    end else if (diff != '0) begin
      if (cnt < prev_r) begin
        rev_nxt = rev_r + REV_W'(1);
      end
      dir_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      rev_r  <= '0;
      dir_r  <= 1'b0;
    end else if (in_fire) begin
      prev_r <= cnt;
      rev_r  <= rev_nxt;
      dir_r  <= dir_nxt;
    end
  end

  logic                    speed_upd;
  logic signed [SUM_W-1:0] sum_nxt;

  ept_speed_window #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .DECIMATION   (DECIMATION)
  ) u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .sample_fire (in_fire),
    .cnt         (cnt),
    .speed_upd   (speed_upd),
    .sum_nxt     (sum_nxt)
  );

  // ---------------------------------------------------------------- stage 1
  logic [POS_W-1:0]        s1_pos_r;
  logic                    s1_dir_r;
  logic                    s1_spd_v_r;
  logic signed [SUM_W-1:0] s1_sum_r;

  always_ff @(posedge clk) begin
    if (s1_ready && in_fire) begin
      s1_pos_r   <= {rev_nxt, cnt};
      s1_dir_r   <= dir_nxt;
      s1_spd_v_r <= speed_upd;
      s1_sum_r   <= sum_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic [POS_W-1:0]         base2;
  logic [POS_W-1:0]         offs;
  logic [2*CNT_W-1:0]       angle_prod;
  logic signed [CMP_W-1:0]  sum_x, lim_x, clamped;
  logic signed [HALF_W-1:0] half;

  assign base2      = {{(POS_W-BASE_W-1){angle_base_r[BASE_W-1]}}, angle_base_r, 1'b0};
  assign offs       = base2 - s1_pos_r - angle_bias_r;
  assign angle_prod = (2*CNT_W)'(s1_pos_r[CNT_W-1:0]) * (2*CNT_W)'(angle_per_count_r);
  assign sum_x      = CMP_W'(s1_sum_r);
  assign lim_x      = signed'(CMP_W'(speed_limit_r));

  always_comb begin
    clamped = sum_x;
    if (sum_x > lim_x) begin
      clamped = lim_x;
    end else if (sum_x < -lim_x) begin
      clamped = -lim_x;
    end
  end

  // arithmetic shift rounds toward minus infinity
  assign half = HALF_W'(clamped >>> 1);

  logic [POS_W-1:0]         s2_pos_r;
  logic [POS_W-1:0]         s2_offs_r;
  logic [ANGLE_W-1:0]       s2_angle_r;
  logic                     s2_dir_r;
  logic                     s2_spd_v_r;
  logic signed [HALF_W-1:0] s2_half_r;

  always_ff @(posedge clk) begin
    if (s2_ready && s1_v_r) begin
      s2_pos_r   <= s1_pos_r;
      s2_offs_r  <= offs;
      s2_angle_r <= angle_prod[ANGLE_W-1:0];
      s2_dir_r   <= s1_dir_r;
      s2_spd_v_r <= s1_spd_v_r;
      s2_half_r  <= half;
    end
  end

  // ----------------------------------------------------------- output stage
  logic signed [PROD_W-1:0] speed_prod;
  logic [SPEED_W-1:0]       speed;

  assign speed_prod = PROD_W'(s2_half_r) * PROD_W'(signed'({1'b0, speed_gain_r}));
  assign speed      = s2_spd_v_r ? speed_prod[SPEED_W-1:0] : '0;

  logic [111:0] out_tdata_r;
  logic         out_tuser_r;

  always_ff @(posedge clk) begin
    if (out_adv && s2_v_r) begin
      out_tdata_r <= {6'd0, speed, s2_angle_r, s2_offs_r, s2_pos_r, s2_dir_r};
      out_tuser_r <= s2_spd_v_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // -------------------------------------------------------------- checks
  a_rev_step : assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_fire) |-> (rev_r == $past(rev_r)) || (rev_r == $past(rev_r) + REV_W'(1))
                       || (rev_r == $past(rev_r) - REV_W'(1)))
    else $error("revolution count moved by more than one");

  a_hold_rev : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (cnt == prev_r) |=> (rev_r == $past(rev_r)) && (dir_r == $past(dir_r)))
    else $error("zero step changed tracking state");

  a_full_stall : assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && s2_v_r && out_v_r && !out_tready |-> !in_tready)
    else $error("sample accepted into a full pipeline");

  a_speed_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[105:81] == '0)
    else $error("speed not zero off the decimation sample");

endmodule

`default_nettype wire

FILE: design/ept_speed_window.sv
`default_nettype none

// Decimated M-method front end: every DECIMATION-th sample the count
// difference since the last speed sample enters a sliding window; the
// updated window sum is presented in the same cycle.
module ept_speed_window
  import ept_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter int DECIMATION   = DEF_DECIMATION,
  localparam int SUM_W = CNT_W + $clog2(WINDOW_DEPTH)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    sample_fire,
  input  wire logic [CNT_W-1:0]        cnt,
  output logic                         speed_upd,
  output logic signed [SUM_W-1:0]      sum_nxt
);

  localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int DEC_W = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;

  logic signed [CNT_W-1:0] win_r [WINDOW_DEPTH];
  logic [PTR_W-1:0]        ptr_r, ptr_nxt;
  logic [DEC_W-1:0]        dec_r;
  logic [CNT_W-1:0]        last_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [CNT_W-1:0] delta;
  logic signed [CNT_W-1:0] oldest;

  assign speed_upd = sample_fire && (dec_r == DEC_W'(DECIMATION - 1));
  assign delta     = signed'(cnt - last_r);
  assign oldest    = win_r[ptr_r];
  assign sum_nxt   = sum_r + SUM_W'(delta) - SUM_W'(oldest);
  assign ptr_nxt   = (ptr_r == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_r + PTR_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        win_r[i] <= '0;
      end
      ptr_r  <= '0;
      dec_r  <= '0;
      last_r <= '0;
      sum_r  <= '0;
    end else if (sample_fire) begin
      if (speed_upd) begin
        dec_r        <= '0;
        win_r[ptr_r] <= delta;
        ptr_r        <= ptr_nxt;
        last_r       <= cnt;
        sum_r        <= sum_nxt;
      end else begin
        dec_r <= dec_r + DEC_W'(1);
      end
    end
  end

endmodule

`default_nettype wire
